// ===== design/mpwa_pkg.sv =====
package mpwa_pkg;

  localparam int MAX_WIDTH   = 64;
  localparam int MAX_HEIGHT  = 64;
  localparam int MAX_KERNEL  = 7;
  localparam int MAX_STRIDE  = 7;
  localparam int PLANE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = 12;
  localparam int SAMPLE_W    = 16;
  localparam int DIM_W       = 7;
  localparam int KERN_W      = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 7;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_SIZE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE       = 3'd3;

  // command kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_POOL  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } state_t;

endpackage

// ===== design/mpwa_ram.sv =====
module mpwa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/max_pool_window_argmax.sv =====
// Max pooling with argmax over one stored image plane of signed Q8.8 samples.
// Command channel: start with in_kind and payload; a command is taken on a
// clock edge where start is high and busy is low.
//   Write (in_kind 0): stores in_sample_value at in_sample_index;
//   busy never rises. Indexes at or beyond width*height are dropped.
//   Pool (in_kind 1): scans the kernel_size square window around
//   (in_out_row*stride, in_out_col*stride), one plane RAM read per window
//   position and one compare per in-range position, later position wins
//   ties. busy stays high through SCAN, DRAIN and EMIT; the result beat is
//   shown in EMIT, the last of them, and no new command is taken before it.
//   The plane RAM has a single read port, so positions are read one at a
//   time. A request outside the output grid returns bad_request with zero
//   value and index in a single busy cycle.
// Result channel: out_valid marks each beat for exactly one cycle; the
// receiver cannot stall, so it must take every beat.
// Config channel: cfg_ready is always high; write only while not busy.
// Out-of-range register values are clamped to the supported ranges.
// Reset (rst_n low, synchronous): registers return to width 8, height 8,
// kernel 3, stride 2; the plane contents are undefined until written.
module max_pool_window_argmax (
  input  logic                                clk,
  input  logic                                rst_n,
  // command channel
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_kind,
  input  logic [mpwa_pkg::ADDR_W-1:0]         in_sample_index,
  input  logic signed [mpwa_pkg::SAMPLE_W-1:0] in_sample_value,
  input  logic [5:0]                          in_out_row,
  input  logic [5:0]                          in_out_col,
  // result channel
  output logic                                out_valid,
  output logic signed [mpwa_pkg::SAMPLE_W-1:0] out_max_value,
  output logic [mpwa_pkg::ADDR_W-1:0]         out_max_index,
  output logic                                out_bad_request,
  // config channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mpwa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mpwa_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // config registers, raw as written
  logic [mpwa_pkg::DIM_W-1:0]  width_r, height_r;
  logic [mpwa_pkg::KERN_W-1:0] kernel_r, stride_r;

  // clamped working values
  logic [mpwa_pkg::DIM_W-1:0]  w_c, h_c;
  logic [mpwa_pkg::KERN_W-1:0] k_c, s_c;
  logic [1:0]                  half_c;

  mpwa_pkg::state_t state_r, state_nxt;

  logic [mpwa_pkg::KERN_W-1:0]   ky_r, kx_r;
  logic signed [10:0]            r0_r, c0_r;
  logic                          bad_r;
  logic                          vld_p_r;
  logic [mpwa_pkg::ADDR_W-1:0]   pos_p_r;
  logic signed [mpwa_pkg::SAMPLE_W-1:0] best_r;
  logic [mpwa_pkg::ADDR_W-1:0]   best_idx_r;
  logic                          found_r;

  logic                          accept, pool_go, last_pos;
  logic [8:0]                    row_org, col_org;
  logic                          grid_bad;
  logic [12:0]                   plane_size;
  logic                          wr_en;
  logic signed [10:0]            r_s, c_s;
  logic                          in_rng;
  logic [12:0]                   pos_full;
  logic [mpwa_pkg::ADDR_W-1:0]   pos;
  logic                          ram_re;
  logic [mpwa_pkg::SAMPLE_W-1:0] ram_rdata;
  logic signed [mpwa_pkg::SAMPLE_W-1:0] rd_val;
  logic                          take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 7'd8;
      height_r <= 7'd8;
      kernel_r <= 3'd3;
      stride_r <= 3'd2;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mpwa_pkg::CFG_IMAGE_WIDTH:  width_r  <= cfg_data;
        mpwa_pkg::CFG_IMAGE_HEIGHT: height_r <= cfg_data;
        mpwa_pkg::CFG_KERNEL_SIZE:  kernel_r <= cfg_data[mpwa_pkg::KERN_W-1:0];
        mpwa_pkg::CFG_STRIDE:       stride_r <= cfg_data[mpwa_pkg::KERN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_r == '0)                                   w_c = 7'd1;
    else if (width_r > 7'(mpwa_pkg::MAX_WIDTH))          w_c = 7'(mpwa_pkg::MAX_WIDTH);
    else                                                 w_c = width_r;
    if (height_r == '0)                                  h_c = 7'd1;
    else if (height_r > 7'(mpwa_pkg::MAX_HEIGHT))        h_c = 7'(mpwa_pkg::MAX_HEIGHT);
    else                                                 h_c = height_r;
    if (kernel_r == '0)                                  k_c = 3'd1;
    else if (kernel_r > 3'(mpwa_pkg::MAX_KERNEL))        k_c = 3'(mpwa_pkg::MAX_KERNEL);
    else                                                 k_c = kernel_r;
    if (stride_r == '0)                                  s_c = 3'd1;
    else if (stride_r > 3'(mpwa_pkg::MAX_STRIDE))        s_c = 3'(mpwa_pkg::MAX_STRIDE);
    else                                                 s_c = stride_r;
  end

  // centering offset (k-1)/2
  assign half_c = 2'((k_c - 3'd1) >> 1);

  // command decode
  assign accept  = start && !busy;
  assign pool_go = accept && (in_kind == mpwa_pkg::KIND_POOL);

  // origin of the window centre; row < rows  <=>  row*s <= h-1
  assign row_org  = 9'(in_out_row) * 9'(s_c);
  assign col_org  = 9'(in_out_col) * 9'(s_c);
  assign grid_bad = (row_org > 9'(h_c - 7'd1)) || (col_org > 9'(w_c - 7'd1));

  assign plane_size = 13'(w_c) * 13'(h_c);
  assign wr_en = accept && (in_kind == mpwa_pkg::KIND_WRITE) &&
                 (13'(in_sample_index) < plane_size);

  // current window position
  assign r_s    = r0_r + $signed(11'(ky_r));
  assign c_s    = c0_r + $signed(11'(kx_r));
  assign in_rng = !r_s[10] && (r_s < $signed(11'(h_c))) &&
                  !c_s[10] && (c_s < $signed(11'(w_c)));
  // in range keeps r*w+c below the plane depth
  assign pos_full = 13'(r_s[5:0]) * 13'(w_c) + 13'(c_s[5:0]);
  assign pos      = pos_full[mpwa_pkg::ADDR_W-1:0];
  assign last_pos = (ky_r == k_c - 3'd1) && (kx_r == k_c - 3'd1);

  mpwa_ram #(
    .WIDTH (mpwa_pkg::SAMPLE_W),
    .DEPTH (mpwa_pkg::PLANE_DEPTH)
  ) u_plane (
    .clk   (clk),
    .we    (wr_en),
    .waddr (in_sample_index),
    .wdata (in_sample_value),
    .re    (ram_re),
    .raddr (pos),
    .rdata (ram_rdata)
  );

  // read data lines up with vld_p_r / pos_p_r of the previous cycle
  assign rd_val = $signed(ram_rdata);
  assign take   = vld_p_r && (!found_r || (best_r <= rd_val));

  // sequencer: next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mpwa_pkg::ST_IDLE: begin
        if (pool_go) begin
          state_nxt = grid_bad ? mpwa_pkg::ST_EMIT : mpwa_pkg::ST_SCAN;
        end
      end
      mpwa_pkg::ST_SCAN: begin
        if (last_pos) begin
          state_nxt = mpwa_pkg::ST_DRAIN;
        end
      end
      mpwa_pkg::ST_DRAIN: state_nxt = mpwa_pkg::ST_EMIT;
      mpwa_pkg::ST_EMIT:  state_nxt = mpwa_pkg::ST_IDLE;
      default:            state_nxt = mpwa_pkg::ST_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    busy      = 1'b1;
    ram_re    = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      mpwa_pkg::ST_IDLE:  busy = 1'b0;
      mpwa_pkg::ST_SCAN:  ram_re = 1'b1;
      mpwa_pkg::ST_DRAIN: ;
      mpwa_pkg::ST_EMIT:  out_valid = 1'b1;
      default:            busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mpwa_pkg::ST_IDLE;
      vld_p_r <= 1'b0;
      found_r <= 1'b0;
      ky_r    <= '0;
      kx_r    <= '0;
    end else begin
      state_r <= state_nxt;
      vld_p_r <= (state_r == mpwa_pkg::ST_SCAN) && in_rng;
      if (pool_go) begin
        ky_r    <= '0;
        kx_r    <= '0;
        found_r <= 1'b0;
      end else if (state_r == mpwa_pkg::ST_SCAN) begin
        if (kx_r == k_c - 3'd1) begin
          kx_r <= '0;
          ky_r <= ky_r + 3'd1;
        end else begin
          kx_r <= kx_r + 3'd1;
        end
      end
      if (take) begin
        found_r <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    pos_p_r <= pos;
    if (pool_go) begin
      r0_r       <= $signed({2'b00, row_org}) - $signed(11'(half_c));
      c0_r       <= $signed({2'b00, col_org}) - $signed(11'(half_c));
      bad_r      <= grid_bad;
      best_r     <= '0;
      best_idx_r <= '0;
    end else if (take) begin
      best_r     <= rd_val;
      best_idx_r <= pos_p_r;
    end
  end

  assign out_max_value   = best_r;
  assign out_max_index   = best_idx_r;
  assign out_bad_request = bad_r;

endmodule
